/* design/tsob_pkg.sv */
package tsob_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_DEPTH = 1024;
    localparam int DEF_WORD_BITS = 32;

    // Fixed field widths of the stream and configuration channels.
    localparam int REQ_W     = 3;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CAP_W     = 11;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_L = 3'd0,
        REQ_PUSH_R = 3'd1,
        REQ_POP_L  = 3'd2,
        REQ_POP_R  = 3'd3,
        REQ_PEEK_L = 3'd4,
        REQ_PEEK_R = 3'd5
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE     = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } stat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // capture the request and read the store
        logic exec;     // apply the request and load the result register
    } tsob_cmd_t;

endpackage

/* design/tsob_ctrl.sv */
module tsob_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output tsob_pkg::tsob_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign out_free   = !out_valid_reg || m_tready;
    assign cmd.accept = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.exec   = (state_reg == ST_EXEC) && out_free;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* design/tsob_dp.sv */
module tsob_dp #(
    parameter int MAX_DEPTH = tsob_pkg::DEF_MAX_DEPTH,
    parameter int WORD_BITS = tsob_pkg::DEF_WORD_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tsob_pkg::tsob_cmd_t            cmd,
    input  logic                           cfg_write,
    input  logic [tsob_pkg::CAP_W-1:0]     cfg_data,
    input  logic [tsob_pkg::S_TDATA_W-1:0] s_tdata,
    output logic [tsob_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int EFF_MAX = (MAX_DEPTH < 2047) ? MAX_DEPTH : 2047;
    localparam int CNT_W   = $clog2(EFF_MAX + 1);
    localparam int ADDR_W  = $clog2(MAX_DEPTH);
    localparam int VAL_W   = tsob_pkg::VAL_W;
    localparam int REQ_W   = tsob_pkg::REQ_W;
    localparam int PAD_W   = tsob_pkg::M_TDATA_W - VAL_W - tsob_pkg::STAT_W - 3;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [CNT_W-1:0] c);
        logic [CNT_W+ADDR_W-1:0] w;
        w = {{ADDR_W{1'b0}}, c};
        return w[ADDR_W-1:0];
    endfunction

    function automatic logic [WORD_BITS-1:0] to_word(input logic [VAL_W-1:0] v);
        logic [WORD_BITS+VAL_W-1:0] w;
        w = {{WORD_BITS{1'b0}}, v};
        return w[WORD_BITS-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] to_val(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS+VAL_W-1:0] w;
        w = {{VAL_W{1'b0}}, v};
        return w[VAL_W-1:0];
    endfunction

    logic [WORD_BITS-1:0] word_store [MAX_DEPTH];

    logic [tsob_pkg::CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0]           left_reg, left_next;
    logic [CNT_W-1:0]           right_reg, right_next;
    logic [CNT_W-1:0]           eff_cap;
    logic [CNT_W-1:0]           right_top;
    logic                       full_now;

    logic [REQ_W-1:0]     req_reg;
    logic [VAL_W-1:0]     val_reg;
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [REQ_W-1:0]     s_req;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 wr_en;

    logic [VAL_W-1:0]            res_val;
    tsob_pkg::stat_t             res_stat;
    logic [CNT_W:0]              sum_next;

    logic [VAL_W-1:0]  out_val_reg;
    tsob_pkg::stat_t   out_stat_reg;
    logic              out_le_reg, out_re_reg, out_full_reg;

    always_comb begin
        if (int'(cap_reg) > MAX_DEPTH) begin
            eff_cap = CNT_W'(MAX_DEPTH);
        end else begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    assign right_top = eff_cap - right_reg;
    assign full_now  = ({1'b0, left_reg} + {1'b0, right_reg}) >= {1'b0, eff_cap};

    // Read address from the request as it arrives; the counts are stable then.
    assign s_req = s_tdata[REQ_W-1:0];
    always_comb begin
        if (s_req == tsob_pkg::REQ_POP_L || s_req == tsob_pkg::REQ_PEEK_L) begin
            rd_addr = to_addr(left_reg - CNT_W'(1));
        end else begin
            rd_addr = to_addr(right_top);
        end
    end

    always_comb begin
        left_next  = left_reg;
        right_next = right_reg;
        res_val    = '0;
        res_stat   = tsob_pkg::ST_DONE;
        wr_en      = 1'b0;
        wr_addr    = to_addr(left_reg);
        unique case (req_reg)
            tsob_pkg::REQ_PUSH_L: begin
                if (full_now) begin
                    res_stat = tsob_pkg::ST_OVERFLOW;
                end else begin
                    wr_en     = 1'b1;
                    left_next = left_reg + CNT_W'(1);
                end
            end
            tsob_pkg::REQ_PUSH_R: begin
                wr_addr = to_addr(right_top - CNT_W'(1));
                if (full_now) begin
                    res_stat = tsob_pkg::ST_OVERFLOW;
                end else begin
                    wr_en      = 1'b1;
                    right_next = right_reg + CNT_W'(1);
                end
            end
            tsob_pkg::REQ_POP_L, tsob_pkg::REQ_PEEK_L: begin
                if (left_reg == '0) begin
                    res_val  = to_val({WORD_BITS{1'b1}});
                    res_stat = tsob_pkg::ST_EMPTY;
                end else begin
                    res_val = to_val(rd_data_reg);
                    if (req_reg == tsob_pkg::REQ_POP_L) begin
                        left_next = left_reg - CNT_W'(1);
                    end
                end
            end
            tsob_pkg::REQ_POP_R, tsob_pkg::REQ_PEEK_R: begin
                if (right_reg == '0) begin
                    res_val  = to_val({WORD_BITS{1'b1}});
                    res_stat = tsob_pkg::ST_EMPTY;
                end else begin
                    res_val = to_val(rd_data_reg);
                    if (req_reg == tsob_pkg::REQ_POP_R) begin
                        right_next = right_reg - CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign sum_next = {1'b0, left_next} + {1'b0, right_next};

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rd_data_reg <= word_store[rd_addr];
        end
        if (cmd.exec && wr_en) begin
            word_store[wr_addr] <= to_word(val_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg <= s_req;
            val_reg <= s_tdata[REQ_W +: VAL_W];
        end
        if (cmd.exec) begin
            out_val_reg  <= res_val;
            out_stat_reg <= res_stat;
            out_le_reg   <= (left_next == '0);
            out_re_reg   <= (right_next == '0);
            out_full_reg <= (sum_next >= {1'b0, eff_cap});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= tsob_pkg::CAP_RESET;
            left_reg  <= '0;
            right_reg <= '0;
        end else if (cfg_write) begin
            cap_reg   <= cfg_data;
            left_reg  <= '0;
            right_reg <= '0;
        end else if (cmd.exec) begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign m_tdata = {{PAD_W{1'b0}}, out_full_reg, out_re_reg, out_le_reg,
                      out_stat_reg, out_val_reg};

endmodule

/* design/two_stacks_one_buffer_top.sv */
// Two stacks in one word store, one request at a time.
// A request is captured and the store read in the idle state; its result is loaded
// in the execution state, after the registered store read and once the result register
// is free. A new request is taken only after the last one leaves execution; one further
// request can be taken while a result waits on m_tready, and it then holds in execution until that result leaves.
// Reset (aresetn low, synchronous): both stacks empty, capacity 1024, store untouched.
module two_stacks_one_buffer_top #(
    parameter int MAX_DEPTH = tsob_pkg::DEF_MAX_DEPTH,
    parameter int WORD_BITS = tsob_pkg::DEF_WORD_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // Capacity register write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tsob_pkg::CAP_W-1:0]     cfg_data,

    // Request channel.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // From bit 0: req_type[2:0], push_value[34:3], zero padding[39:35].
    input  logic [tsob_pkg::S_TDATA_W-1:0] s_tdata,

    // Result channel.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // From bit 0: read_value[31:0], status[33:32], left_empty[34],
    // right_empty[35], is_full[36], zero padding[39:37].
    output logic [tsob_pkg::M_TDATA_W-1:0] m_tdata
);

    tsob_pkg::tsob_cmd_t cmd;

    // The capacity register can always be written; the user must write only while
    // no request is in flight, which the block does not enforce. Each write empties both stacks.
    assign cfg_ready = 1'b1;

    // The controller sequences each request through capture and execution and
    // owns the valid flag of the result register.
    tsob_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // The datapath holds the store, both stack counts, the capacity and the
    // result payload.
    tsob_dp #(
        .MAX_DEPTH (MAX_DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cfg_write (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata)
    );

endmodule
